// ===== rtl/core/cpch_pkg.sv =====
// Shared widths, constants and the per-pixel state record of the peak centroid core.
`timescale 1ns / 1ps
`default_nettype none

package cpch_pkg;

  // Field widths of the stream channels.
  localparam int ADDR_W   = 18;
  localparam int SEC_W    = 8;
  localparam int SAMP_W   = 8;
  localparam int CON_W    = 13;
  localparam int HEIGHT_W = 18;
  localparam int STEPS_W  = 9;

  // Sizing of the per-pixel state store.
  localparam int PIXEL_COUNT = 262144;
  localparam int PIX_IDX_W   = $clog2(PIXEL_COUNT);
  localparam int MAX_STEPS   = 256;

  // Configuration register map.
  localparam int PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_STEP_COUNT = 2'd0;

  // One entry of the per-pixel state: earlier peaks, peak and the values after it.
  typedef struct packed {
    logic [2:0][CON_W-1:0] after_values;
    logic [2:0][CON_W-1:0] before_values;
    logic [SEC_W-1:0]      peak_section;
    logic [CON_W-1:0]      peak_value;
  } pix_state_t;

  localparam int STATE_W = $bits(pix_state_t);

endpackage

`default_nettype wire

// ===== rtl/core/cpch_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cpch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/confocal_peak_centroid_height_core.sv =====
// Top level of the confocal peak search and centroid height core.
//
// Usage: each input transfer carries one pixel's three pattern samples for one
// scan section. The core forms the contrast, updates that pixel's peak record in
// an on-chip state RAM, and on the last section (section == step_count - 1) issues
// one output transfer with the centroid height and the peak contrast. Other
// items give no output transfer.
// Channels: in_* and out_* use valid/ready; step_count is written over the APB
// port at byte address 0 (pready is always high). The user must write step_count
// only while the core is idle; the core itself does not enforce this.
// Throughput: one item per cycle while out_* is not stalled; the contrast square
// root and the height division are each split into one-bit steps, one per
// pipeline stage, and the state RAM does one read and one write per cycle.
// Back-to-back items to the same pixel are served by a write-forwarding register.
// Stall: when a result waits and out_ready is low, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// Reset: clears valid bits and sets step_count to 1. The state RAM is not
// cleared; every pixel must see section 0 before its other sections.
`timescale 1ns / 1ps
`default_nettype none

module confocal_peak_centroid_height_core
  import cpch_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [ADDR_W-1:0]      in_pixel_addr,
  input  wire logic [SEC_W-1:0]       in_section,
  input  wire logic [SAMP_W-1:0]      in_sample_a,
  input  wire logic [SAMP_W-1:0]      in_sample_b,
  input  wire logic [SAMP_W-1:0]      in_sample_c,
  // result stream
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ADDR_W-1:0]           out_pixel_addr,
  output logic signed [HEIGHT_W-1:0]  out_height_q8,
  output logic [CON_W-1:0]            out_peak_contrast,
  output logic                        out_no_weight,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int SQ_STEPS  = CON_W;          // one root bit per stage
  localparam int DIV_STEPS = HEIGHT_W;       // one quotient bit per stage
  localparam int V_W       = 2 * CON_W;      // radicand width
  localparam int SUM_W     = 18;             // sum of three squares
  localparam int DEN_W     = 16;             // sum of seven weights
  localparam int WS_W      = 18;             // signed offset-weighted sum
  localparam int NUM_W     = 26;             // signed first moment
  localparam int MAG_W     = NUM_W - 1;
  localparam int N_W       = MAG_W + 9;      // 2 * |num| * 256 + den
  localparam int D_W       = DEN_W + 1;      // 2 * den
  localparam int ST_RD     = 2 + SQ_STEPS - 1;   // stage that issues the RAM read
  localparam int ST_UPD    = ST_RD + 1;          // stage holding the final root
  localparam int LAST      = ST_UPD + 5 + DIV_STEPS - 1;

  typedef struct packed {
    logic              valid;
    logic              emit;
    logic [ADDR_W-1:0] addr;
    logic [SEC_W-1:0]  sec;
  } meta_t;

  typedef struct packed {
    logic [V_W-1:0]   rem;
    logic [CON_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [N_W-1:0]      rem;
    logic [HEIGHT_W-1:0] quo;
    logic [D_W-1:0]      dvs;
    logic                neg;
    logic                zero;
    logic [CON_W-1:0]    peak;
  } div_t;

  logic                   adv;
  logic [STEPS_W-1:0]     step_count_r;
  logic [STEPS_W-1:0]     steps_sat;
  logic                   emit_in;
  meta_t                  meta_r [LAST+1];

  logic [SAMP_W-1:0]      a_r, b_r, c_r;
  logic [15:0]            sqa_r, sqb_r, sqc_r;
  logic [V_W-1:0]         v_r;
  sqrt_t                  sq_r [SQ_STEPS];

  logic [STATE_W-1:0]     ram_rdata;
  pix_state_t             cur_st;
  pix_state_t             new_st;
  logic                   fw_hit;
  logic                   lw_valid_r;
  logic [PIX_IDX_W-1:0]   lw_idx_r;
  pix_state_t             lw_data_r;
  logic                   ram_we;

  pix_state_t             st_r;
  logic [DEN_W-1:0]       den_r, den2_r;
  logic signed [WS_W-1:0] wsum_r;
  logic [SEC_W-1:0]       psec_r;
  logic [CON_W-1:0]       pk1_r, pk2_r;
  logic signed [NUM_W-1:0] num_r;
  div_t                   div0_r;
  div_t                   dv_r [DIV_STEPS];

  logic                   out_valid_r;
  logic [ADDR_W-1:0]      out_addr_r;
  logic [HEIGHT_W-1:0]    out_height_r;
  logic [CON_W-1:0]       out_peak_r;
  logic                   out_nw_r;

  // The whole pipeline moves unless a finished result is held up.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Configuration register; APB transfers complete in their access cycle.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_STEP_COUNT) ? {23'd0, step_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= STEPS_W'(1);
    end else if (psel && penable && pwrite && paddr == REG_STEP_COUNT) begin
      step_count_r <= pwdata[STEPS_W-1:0];
    end
  end

  // Out-of-range step counts are saturated to the supported span.
  always_comb begin
    if (step_count_r == '0) begin
      steps_sat = STEPS_W'(1);
    end else if (step_count_r > STEPS_W'(MAX_STEPS)) begin
      steps_sat = STEPS_W'(MAX_STEPS);
    end else begin
      steps_sat = step_count_r;
    end
  end

  assign emit_in = (({1'b0, in_section} + STEPS_W'(1)) == steps_sat);

  // Item tags travel alongside the data, one slot per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST; i++) begin
        meta_r[i].valid <= 1'b0;
      end
    end else if (adv) begin
      meta_r[0].valid <= in_valid;
      meta_r[0].emit  <= emit_in;
      meta_r[0].addr  <= in_pixel_addr;
      meta_r[0].sec   <= in_section;
      for (int i = 1; i <= LAST; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  // Contrast front end: samples, squared pairwise differences, radicand.
  always_ff @(posedge clk) begin
    logic signed [SAMP_W:0]   dab, dac, dbc;
    logic signed [2*SAMP_W+1:0] pab, pac, pbc;
    dab = $signed({1'b0, a_r}) - $signed({1'b0, b_r});
    dac = $signed({1'b0, a_r}) - $signed({1'b0, c_r});
    dbc = $signed({1'b0, b_r}) - $signed({1'b0, c_r});
    pab = dab * dab;
    pac = dac * dac;
    pbc = dbc * dbc;
    if (adv) begin
      a_r   <= in_sample_a;
      b_r   <= in_sample_b;
      c_r   <= in_sample_c;
      sqa_r <= pab[15:0];
      sqb_r <= pac[15:0];
      sqc_r <= pbc[15:0];
      v_r   <= {SUM_W'(sqa_r) + SUM_W'(sqb_r) + SUM_W'(sqc_r), 8'd0};
    end
  end

  // Square root, one result bit per stage, most significant bit first.
  function automatic sqrt_t sqrt_step(sqrt_t s, int k);
    logic [V_W:0] trial;
    sqrt_t        r;
    trial = ((V_W+1)'(s.root) << (k + 1)) | ((V_W+1)'(1) << (2 * k));
    r = s;
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[V_W-1:0];
      r.root = s.root | (CON_W'(1) << k);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    sqrt_t seed;
    seed.rem  = v_r;
    seed.root = '0;
    if (adv) begin
      sq_r[0] <= sqrt_step(seed, SQ_STEPS - 1);
      for (int j = 1; j < SQ_STEPS; j++) begin
        sq_r[j] <= sqrt_step(sq_r[j-1], SQ_STEPS - 1 - j);
      end
    end
  end

  // Per-pixel state store: read one stage ahead, written back on update.
  cpch_ram #(
    .WIDTH (STATE_W),
    .DEPTH (PIXEL_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (meta_r[ST_UPD].addr[PIX_IDX_W-1:0]),
    .wdata (new_st),
    .re    (adv),
    .raddr (meta_r[ST_RD].addr[PIX_IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_we = adv && meta_r[ST_UPD].valid;

  // The write that lands on the same edge as this item's read is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (adv) begin
      lw_valid_r <= meta_r[ST_UPD].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lw_idx_r  <= meta_r[ST_UPD].addr[PIX_IDX_W-1:0];
      lw_data_r <= new_st;
    end
  end

  assign fw_hit = lw_valid_r && (lw_idx_r == meta_r[ST_UPD].addr[PIX_IDX_W-1:0]);

  // Peak tracking update of the pixel record.
  always_comb begin
    logic [CON_W-1:0] con;
    logic [SEC_W:0]   sec_gap;
    con     = sq_r[SQ_STEPS-1].root;
    cur_st  = fw_hit ? lw_data_r : pix_state_t'(ram_rdata);
    sec_gap = {1'b0, meta_r[ST_UPD].sec} - {1'b0, cur_st.peak_section};
    new_st  = cur_st;
    if (meta_r[ST_UPD].sec == '0) begin
      new_st.peak_value    = con;
      new_st.peak_section  = '0;
      new_st.before_values = '0;
      new_st.after_values  = '0;
    end else if (con >= cur_st.peak_value) begin
      new_st.before_values[2] = cur_st.before_values[1];
      new_st.before_values[1] = cur_st.before_values[0];
      new_st.before_values[0] = cur_st.peak_value;
      new_st.peak_value       = con;
      new_st.peak_section     = meta_r[ST_UPD].sec;
    end else if (sec_gap == (SEC_W+1)'(1)) begin
      new_st.after_values[0] = con;
    end else if (sec_gap == (SEC_W+1)'(2)) begin
      new_st.after_values[1] = con;
    end else if (sec_gap == (SEC_W+1)'(3)) begin
      new_st.after_values[2] = con;
    end
  end

  // Centroid: weight sum and offset moment, then the full first moment.
  always_ff @(posedge clk) begin
    logic signed [WS_W-1:0] w [7];
    logic [NUM_W-1:0]       pd;
    w[0] = WS_W'(st_r.before_values[2]);
    w[1] = WS_W'(st_r.before_values[1]);
    w[2] = WS_W'(st_r.before_values[0]);
    w[3] = WS_W'(st_r.peak_value);
    w[4] = WS_W'(st_r.after_values[0]);
    w[5] = WS_W'(st_r.after_values[1]);
    w[6] = WS_W'(st_r.after_values[2]);
    pd   = NUM_W'(psec_r) * NUM_W'(den_r);
    if (adv) begin
      st_r   <= new_st;
      den_r  <= DEN_W'(w[0] + w[1] + w[2] + w[3] + w[4] + w[5] + w[6]);
      wsum_r <= WS_W'(3 * (w[6] - w[0]) + 2 * (w[5] - w[1]) + (w[4] - w[2]));
      psec_r <= st_r.peak_section;
      pk1_r  <= st_r.peak_value;
      num_r  <= $signed(pd) + NUM_W'(wsum_r);
      den2_r <= den_r;
      pk2_r  <= pk1_r;
    end
  end

  // Rounded division: (2*|num|*256 + den) / (2*den), one quotient bit per stage.
  function automatic div_t div_step(div_t s, int k);
    logic [N_W:0] sub;
    div_t         r;
    sub = (N_W+1)'(s.dvs) << k;
    r   = s;
    if ({1'b0, s.rem} >= sub) begin
      r.rem = s.rem - sub[N_W-1:0];
      r.quo = s.quo | (HEIGHT_W'(1) << k);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    logic [MAG_W-1:0] mag;
    mag = num_r[NUM_W-1] ? MAG_W'(-num_r) : MAG_W'(num_r);
    if (adv) begin
      div0_r.rem  <= {mag, 9'd0} + N_W'(den2_r);
      div0_r.quo  <= '0;
      div0_r.dvs  <= {den2_r, 1'b0};
      div0_r.neg  <= num_r[NUM_W-1];
      div0_r.zero <= (den2_r == '0);
      div0_r.peak <= pk2_r;
      dv_r[0] <= div_step(div0_r, DIV_STEPS - 1);
      for (int j = 1; j < DIV_STEPS; j++) begin
        dv_r[j] <= div_step(dv_r[j-1], DIV_STEPS - 1 - j);
      end
    end
  end

  // Output register: a result waits here until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= meta_r[LAST].valid && meta_r[LAST].emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_addr_r <= meta_r[LAST].addr;
      out_peak_r <= dv_r[DIV_STEPS-1].peak;
      out_nw_r   <= dv_r[DIV_STEPS-1].zero;
      if (dv_r[DIV_STEPS-1].zero) begin
        out_height_r <= '0;
      end else if (dv_r[DIV_STEPS-1].neg) begin
        out_height_r <= -dv_r[DIV_STEPS-1].quo;
      end else begin
        out_height_r <= dv_r[DIV_STEPS-1].quo;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_addr    = out_addr_r;
  assign out_height_q8     = $signed(out_height_r);
  assign out_peak_contrast = out_peak_r;
  assign out_no_weight     = out_nw_r;

  // A zero weight sum always reports a zero height.
  a_nw_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_weight |-> out_height_q8 == '0)
    else $error("no_weight result with nonzero height");

  // The contrast root never exceeds the largest reachable value.
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_contrast <= CON_W'(5770))
    else $error("peak contrast out of range");

  // A new result comes only from a valid last-section item leaving the pipeline.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(meta_r[LAST].valid && meta_r[LAST].emit))
    else $error("result without a last-section item");

  // The state RAM is written only while the pipeline advances.
  a_we_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> in_ready && meta_r[ST_UPD].valid)
    else $error("state write during a stall");

endmodule

`default_nettype wire
